// File: rtl/nllf_pkg.sv
// Shared types and constants of the nonlinear ladder lowpass filter.
// Used by the controller, the datapath and the top level.
package nllf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CF_LEVELS = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COEF    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_K   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TANH_SCALE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SCALE = 3'd4;

    // Five tanh evaluations per sample, four derivatives.
    localparam logic [2:0] LAST_TANH  = 3'd4;
    localparam logic [2:0] LAST_DERIV = 3'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MAG,
        OP_SCALE,
        OP_INDEX,
        OP_LOOK,
        OP_INTERP,
        OP_DERIV,
        OP_UPDATE,
        OP_OUT_MAG,
        OP_OUT_SCALE,
        OP_PUSH
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        logic can_push;
    } t_sts;

endpackage

// File: rtl/nonlinear_ladder_lowpass_filter_unit.sv
// Top level of the four-pole nonlinear ladder lowpass filter.
// Depends on nllf_pkg, nllf_ctrl and nllf_dp.
//
//  Channel  | Direction | Payload
//  s_axis   | in        | tdata[15:0] sample_in
//  m_axis   | out       | tdata[15:0] sample_out, tuser[0] diverged
//  cfg      | in        | 3-bit register index, 17-bit data
//
// Between its transfer and its result being offered, one sample passes through
// five tanh evaluations of five steps each through the one interpolation unit,
// four derivative steps, the state update, two output scaling steps and the
// push into the result register, which waits while the last result is untaken.
// A new sample is taken only while the sequencer is idle; the result register
// lets the next sample start while the last result is still waiting.
// Reset is synchronous and active low; it clears state and restores the registers.
module nonlinear_ladder_lowpass_filter_unit
    import nllf_pkg::*;
#(
    parameter int TANH_TABLE_ENTRIES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [15:0]          i_s_axis_tdata,   // [15:0] sample_in
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [15:0]          o_m_axis_tdata,   // [15:0] sample_out
    output logic [0:0]           o_m_axis_tuser,   // [0] diverged
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd               cmd;
    t_sts               sts;
    logic signed [15:0] sample;
    logic               div;

    nllf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    nllf_dp #(
        .TANH_TABLE_ENTRIES (TANH_TABLE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_sample    ($signed(i_s_axis_tdata)),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_sample    (sample),
        .o_diverged  (div)
    );

    assign o_m_axis_tdata = sample;
    assign o_m_axis_tuser = div;

endmodule

// File: rtl/nllf_ctrl.sv
// Sequencer of the ladder filter: walks one sample through the datapath steps.
// Depends on nllf_pkg.
module nllf_ctrl
    import nllf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_MAG       = 10'b00_0000_0010,
        S_SCALE     = 10'b00_0000_0100,
        S_INDEX     = 10'b00_0000_1000,
        S_LOOK      = 10'b00_0001_0000,
        S_INTERP    = 10'b00_0010_0000,
        S_DERIV     = 10'b00_0100_0000,
        S_UPDATE    = 10'b00_1000_0000,
        S_OUT       = 10'b01_0000_0000,
        S_PUSH      = 10'b10_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_idx, n_idx;
    logic       r_out_second, n_out_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_out_second <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_out_second <= n_out_second;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_out_second = r_out_second;
        o_cmd.op     = OP_NONE;
        o_cmd.idx    = r_idx;
        o_in_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_idx    = '0;
                    n_state  = S_MAG;
                end
            end
            S_MAG: begin
                o_cmd.op = OP_MAG;
                n_state  = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.op = OP_SCALE;
                n_state  = S_INDEX;
            end
            S_INDEX: begin
                o_cmd.op = OP_INDEX;
                n_state  = S_LOOK;
            end
            S_LOOK: begin
                o_cmd.op = OP_LOOK;
                n_state  = S_INTERP;
            end
            S_INTERP: begin
                o_cmd.op = OP_INTERP;
                if (r_idx == LAST_TANH) begin
                    n_idx   = '0;
                    n_state = S_DERIV;
                end else begin
                    n_idx   = r_idx + 3'd1;
                    n_state = S_MAG;
                end
            end
            S_DERIV: begin
                o_cmd.op = OP_DERIV;
                if (r_idx == LAST_DERIV) begin
                    n_state = S_UPDATE;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            S_UPDATE: begin
                o_cmd.op     = OP_UPDATE;
                n_out_second = 1'b0;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!r_out_second) begin
                    o_cmd.op     = OP_OUT_MAG;
                    n_out_second = 1'b1;
                end else begin
                    o_cmd.op = OP_OUT_SCALE;
                    n_state  = S_PUSH;
                end
            end
            S_PUSH: begin
                // Wait here only while the previous result is still untaken.
                if (i_sts.can_push) begin
                    o_cmd.op = OP_PUSH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/nllf_dp.sv
// Datapath of the ladder filter: registers, state, tanh table and arithmetic.
// Depends on nllf_pkg; sequenced by nllf_ctrl.
module nllf_dp
    import nllf_pkg::*;
#(
    parameter int TANH_TABLE_ENTRIES = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0]           i_cfg_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_diverged
);

    localparam int NW = $clog2(TANH_TABLE_ENTRIES + 1);
    localparam int PW = 18 + NW;

    typedef logic [15:0] t_tab [0:TANH_TABLE_ENTRIES];

    // Restoring division, used only while the table is built at elaboration.
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Tanh samples at x = 4i/N from a Lambert continued fraction in Q24.
    function automatic t_tab build_tab();
        t_tab        tb;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] r;
        logic [63:0] t;
        for (int i = 0; i <= TANH_TABLE_ENTRIES; i++) begin
            x  = udiv((64'd4 << 24) * 64'(i), 64'(TANH_TABLE_ENTRIES));
            x2 = (x * x) >> 24;
            r  = 64'(2 * CF_LEVELS + 1) << 24;
            for (int k = CF_LEVELS; k >= 1; k--) begin
                r = (64'(2 * k - 1) << 24) + udiv(x2 << 24, r);
            end
            t     = udiv(x << 24, r);
            tb[i] = 16'((t + 64'd128) >> 8);
        end
        return tb;
    endfunction

    localparam t_tab TANH_TAB = build_tab();

    // Configuration.
    logic [15:0] r_step_coef;
    logic [16:0] r_feedback_k;
    logic [15:0] r_drive_gain;
    logic [15:0] r_tanh_scale;
    logic [15:0] r_output_scale;

    // Filter state.
    logic signed [31:0] r_v  [0:3];
    logic signed [19:0] r_pd [0:3];

    // Working registers.
    logic signed [25:0] r_vin;
    logic signed [49:0] r_fbp;
    logic               r_neg;
    logic [36:0]        r_mag;
    logic [44:0]        r_a;
    logic               r_sat;
    logic [NW-1:0]      r_tidx;
    logic [15:0]        r_frac;
    logic [15:0]        r_lo;
    logic [15:0]        r_hi;
    logic signed [17:0] r_t  [0:4];
    logic signed [19:0] r_d  [0:3];
    logic               r_div;
    logic               r_yneg;
    logic [47:0]        r_ymag;
    logic signed [15:0] r_res;
    logic               r_ovalid;
    logic signed [15:0] r_osample;
    logic               r_odiv;

    logic signed [32:0] vin_prod;
    logic signed [36:0] arg;
    logic [52:0]        a_prod;
    logic [PW-1:0]      p;
    logic signed [16:0] diff;
    logic signed [33:0] ip;
    logic signed [17:0] mg;
    logic signed [18:0] dsum;
    logic signed [35:0] dprod;
    logic signed [33:0] nv [0:3];
    logic signed [48:0] y;
    logic [62:0]        ym;
    logic [38:0]        ysh;

    assign vin_prod = i_sample * $signed({1'b0, r_drive_gain});
    assign a_prod   = r_mag * r_tanh_scale;
    assign p        = PW'(r_a[17:0]) * PW'(TANH_TABLE_ENTRIES);
    assign diff     = $signed({1'b0, r_hi}) - $signed({1'b0, r_lo});
    assign ip       = diff * $signed({1'b0, r_frac});
    assign mg       = r_sat ? $signed({2'b00, TANH_TAB[TANH_TABLE_ENTRIES]})
                            : $signed({2'b00, r_lo}) + ip[33:16];
    assign dprod    = dsum * $signed({1'b0, r_step_coef});
    assign y        = r_v[3] * $signed({1'b0, r_output_scale});
    assign ym       = (63'(r_ymag) << 15) - 63'(r_ymag);
    assign ysh      = ym[62:24];

    always_comb begin
        case (i_cmd.idx)
            3'd0:    arg = 37'(r_v[0]);
            3'd1:    arg = 37'(r_vin) + 37'(r_fbp >>> 14);
            3'd2:    arg = 37'(r_v[1]);
            3'd3:    arg = 37'(r_v[2]);
            default: arg = 37'(r_v[3]);
        endcase
    end

    always_comb begin
        case (i_cmd.idx)
            3'd0:    dsum = -(19'(r_t[0]) + 19'(r_t[1]));
            3'd1:    dsum = 19'(r_t[0]) - 19'(r_t[2]);
            3'd2:    dsum = 19'(r_t[2]) - 19'(r_t[3]);
            default: dsum = 19'(r_t[3]) - 19'(r_t[4]);
        endcase
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            nv[i] = 34'(r_v[i]) + 34'(r_d[i]) + 34'(r_pd[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_coef    <= 16'd4048;
            r_feedback_k   <= 17'd0;
            r_drive_gain   <= 16'd256;
            r_tanh_scale   <= 16'd256;
            r_output_scale <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEP_COEF:    r_step_coef    <= i_cfg_data[15:0];
                CFG_FEEDBACK_K:   r_feedback_k   <= i_cfg_data;
                CFG_DRIVE_GAIN:   r_drive_gain   <= i_cfg_data[15:0];
                CFG_TANH_SCALE:   r_tanh_scale   <= i_cfg_data[15:0];
                CFG_OUTPUT_SCALE: r_output_scale <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_v[i]  <= '0;
                r_pd[i] <= '0;
            end
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_PUSH) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd.op)
                OP_UPDATE: begin
                    if (nv[3] > 34'sd2147483647 || nv[3] < -34'sd2147483648) begin
                        for (int i = 0; i < 4; i++) begin
                            r_v[i]  <= '0;
                            r_pd[i] <= '0;
                        end
                    end else begin
                        for (int i = 0; i < 4; i++) begin
                            if (nv[i] > 34'sd2147483647) begin
                                r_v[i] <= 32'sh7FFFFFFF;
                            end else if (nv[i] < -34'sd2147483648) begin
                                r_v[i] <= 32'sh80000000;
                            end else begin
                                r_v[i] <= nv[i][31:0];
                            end
                            r_pd[i] <= r_d[i];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_vin <= vin_prod[32:7];
                r_fbp <= r_v[3] * $signed({1'b0, r_feedback_k});
                r_div <= 1'b0;
            end
            OP_MAG: begin
                r_neg <= arg[36];
                r_mag <= arg[36] ? 37'(-arg) : 37'(arg);
            end
            OP_SCALE: begin
                r_a <= a_prod[52:8];
            end
            OP_INDEX: begin
                r_sat  <= |r_a[44:18];
                r_tidx <= p[PW-1:18];
                r_frac <= p[17:2];
            end
            OP_LOOK: begin
                r_lo <= TANH_TAB[r_tidx];
                r_hi <= TANH_TAB[r_tidx + NW'(1)];
            end
            OP_INTERP: begin
                r_t[i_cmd.idx] <= r_neg ? -mg : mg;
            end
            OP_DERIV: begin
                r_d[i_cmd.idx[1:0]] <= dprod[35:16];
            end
            OP_UPDATE: begin
                r_div <= nv[3] > 34'sd2147483647 || nv[3] < -34'sd2147483648;
            end
            OP_OUT_MAG: begin
                r_yneg <= y[48];
                r_ymag <= y[48] ? 48'(-y) : 48'(y);
            end
            OP_OUT_SCALE: begin
                if (ysh > 39'd32767) begin
                    r_res <= r_yneg ? -16'sd32767 : 16'sd32767;
                end else begin
                    r_res <= r_yneg ? -$signed(ysh[15:0]) : $signed(ysh[15:0]);
                end
            end
            OP_PUSH: begin
                r_osample <= r_res;
                r_odiv    <= r_div;
            end
            default: ;
        endcase
    end

    assign o_sts.can_push = !r_ovalid || i_out_ready;
    assign o_out_valid    = r_ovalid;
    assign o_sample       = r_osample;
    assign o_diverged     = r_odiv;

endmodule

// File: rtl/nllf_checker.sv
// Port-level checks of the ladder filter top level, attached by bind.
// Depends on nllf_pkg and nonlinear_ladder_lowpass_filter_unit.
module nllf_checker
    import nllf_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic [15:0]          i_s_axis_tdata,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [15:0]          o_m_axis_tdata,
    input logic [0:0]           o_m_axis_tuser,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_idx,
    input logic [CFG_W-1:0]     i_cfg_data
);

    // A stalled result must hold.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // A cleared filter always reports a zero sample.
    a_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == 16'h0000)
        else $error("diverged result not zero");

    // The limiter never lets the most negative code through.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata != 16'h8000)
        else $error("output outside saturation range");

    // One sample at a time: the input closes after a transfer.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after transfer");

endmodule

bind nonlinear_ladder_lowpass_filter_unit nllf_checker u_nllf_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the nonlinear ladder lowpass filter unit.
// Depends on nllf_pkg and the RTL top level; a fixed-point filter model predicts every sample.
module testbench;
    import nllf_pkg::*;

    localparam int TANH_POINTS = 256;
    localparam int DRAIN_WAIT  = 80;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SHOWN_MAX   = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_IDX = '1;

    typedef struct {
        logic signed [15:0] sample;
        logic               diverged;
    } t_filtered;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_vld = 1'b0;
    logic                 s_rdy;
    logic [15:0]          s_data = '0;
    logic                 m_vld;
    logic                 m_rdy = 1'b0;
    logic [15:0]          m_data;
    logic [0:0]           m_user;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    nonlinear_ladder_lowpass_filter_unit #(.TANH_TABLE_ENTRIES(TANH_POINTS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_vld), .o_s_axis_tready(s_rdy), .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_vld), .i_m_axis_tready(m_rdy), .o_m_axis_tdata(m_data),
        .o_m_axis_tuser(m_user),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Filter model state.
    longint tanh_lut [0:TANH_POINTS];
    longint step_c, fb_k, drive, t_scale, o_scale;
    longint stage_v [4];
    longint prev_inc [4];

    logic [15:0] sample_q [$];
    t_filtered   filtered_q [$];
    int          mismatches = 0;
    int          cycles = 0;
    int          results_seen = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          recv_hold = 0;
    bit          hold_done = 0;
    bit          quiet;

    function automatic void build_tanh_lut();
        longint unsigned x, x2, r, t;
        for (int i = 0; i <= TANH_POINTS; i++) begin
            x  = (64'd4 << 24) * i / TANH_POINTS;
            x2 = (x * x) >> 24;
            r  = 64'd49 << 24;
            for (int k = 24; k >= 1; k--)
                r = (longint'(2 * k - 1) << 24) + (x2 << 24) / r;
            t = (x << 24) / r;
            tanh_lut[i] = longint'((t + 128) >> 8);
        end
    endfunction

    function automatic longint tanh_fixed(longint v);
        longint unsigned mag, a, p;
        longint lo, hi, r;
        int idx;
        mag = (v < 0) ? longint'(-v) : v;
        if (mag > (64'd1 << 40)) mag = 64'd1 << 40;
        a = (mag * t_scale) >> 8;
        if (a >= 4 * 65536) begin
            r = tanh_lut[TANH_POINTS];
        end else begin
            p   = a * TANH_POINTS;
            idx = int'(p >> 18);
            lo  = tanh_lut[idx];
            hi  = tanh_lut[idx + 1];
            r   = lo + (((hi - lo) * longint'((p >> 2) & 64'hFFFF)) >>> 16);
        end
        return (v < 0) ? -r : r;
    endfunction

    function automatic void clear_ladder();
        for (int i = 0; i < 4; i++) begin
            stage_v[i]  = 0;
            prev_inc[i] = 0;
        end
    endfunction

    // Advances the ladder by one sample and returns the filtered output.
    function automatic t_filtered filter_sample(logic signed [15:0] x);
        t_filtered res;
        longint vin, fb, t0, tin, t1, t2, t3, y;
        longint inc [4];
        longint nv [4];
        longint unsigned mag;
        vin = (longint'(x) * drive) >>> 7;
        fb  = (stage_v[3] * fb_k) >>> 14;
        t0  = tanh_fixed(stage_v[0]);
        tin = tanh_fixed(vin + fb);
        t1  = tanh_fixed(stage_v[1]);
        t2  = tanh_fixed(stage_v[2]);
        t3  = tanh_fixed(stage_v[3]);
        inc[0] = (-(step_c * (t0 + tin))) >>> 16;
        inc[1] = (step_c * (t0 - t1)) >>> 16;
        inc[2] = (step_c * (t1 - t2)) >>> 16;
        inc[3] = (step_c * (t2 - t3)) >>> 16;
        for (int i = 0; i < 4; i++) nv[i] = stage_v[i] + inc[i] + prev_inc[i];
        if (nv[3] > 64'sh7FFFFFFF || nv[3] < -64'sh80000000) begin
            // The last stage ran away: the ladder restarts from rest.
            clear_ladder();
            res.sample   = '0;
            res.diverged = 1'b1;
            return res;
        end
        for (int i = 0; i < 3; i++) begin
            if (nv[i] > 64'sh7FFFFFFF) nv[i] = 64'sh7FFFFFFF;
            if (nv[i] < -64'sh80000000) nv[i] = -64'sh80000000;
        end
        for (int i = 0; i < 4; i++) begin
            stage_v[i]  = nv[i];
            prev_inc[i] = inc[i];
        end
        y   = stage_v[3] * o_scale;
        mag = (y < 0) ? longint'(-y) : y;
        mag = (mag * 32767) >> 24;
        if (mag > 32767) mag = 32767;
        res.sample   = (y < 0) ? -16'(mag) : 16'(mag);
        res.diverged = 1'b0;
        return res;
    endfunction

    function automatic int random_gap();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 60) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        quiet  <= ((cycles / 3000) % 4) == 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Sample driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_vld <= 1'b0;
        end else if (!s_vld || s_rdy) begin
            if (s_vld) filtered_q.push_back(filter_sample(s_data));
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_vld    <= 1'b0;
            end else if (sample_q.size() > 0) begin
                s_data   <= sample_q.pop_front();
                s_vld    <= 1'b1;
                send_gap <= random_gap();
            end else begin
                s_vld <= 1'b0;
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge i_clk) begin
        t_filtered want;
        if (!i_rst_n) begin
            m_rdy <= 1'b0;
        end else begin
            if (m_vld && m_rdy) begin
                results_seen <= results_seen + 1;
                if (filtered_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < SHOWN_MAX)
                        $display("unexpected transfer: sample %0d diverged %0b",
                                 $signed(m_data), m_user[0]);
                end else begin
                    want = filtered_q.pop_front();
                    if (m_data !== want.sample || m_user[0] !== want.diverged) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < SHOWN_MAX)
                            $display("mismatch: sample exp %0d got %0d, diverged exp %0b got %0b",
                                     want.sample, $signed(m_data), want.diverged, m_user[0]);
                    end
                end
            end
            // One long hold-off lets the result register and the input side back up.
            if (!hold_done && results_seen == 100) begin
                hold_done <= 1'b1;
                recv_hold <= 400;
                m_rdy     <= 1'b0;
            end else if (recv_hold > 0) begin
                recv_hold <= recv_hold - 1;
                m_rdy     <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_rdy    <= 1'b0;
            end else begin
                m_rdy    <= 1'b1;
                recv_gap <= ($urandom_range(9) == 0) ? random_gap() : 0;
            end
        end
    end

    task automatic wait_idle();
        do @(posedge i_clk);
        while (sample_q.size() != 0 || s_vld || filtered_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_STEP_COEF:    step_c  = val[15:0];
            CFG_FEEDBACK_K:   fb_k    = val;
            CFG_DRIVE_GAIN:   drive   = val[15:0];
            CFG_TANH_SCALE:   t_scale = val[15:0];
            CFG_OUTPUT_SCALE: o_scale = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_filter(int sc, int k, int dg, int ts, int os);
        write_reg(CFG_STEP_COEF, CFG_W'(sc));
        write_reg(CFG_FEEDBACK_K, CFG_W'(k));
        write_reg(CFG_DRIVE_GAIN, CFG_W'(dg));
        write_reg(CFG_TANH_SCALE, CFG_W'(ts));
        write_reg(CFG_OUTPUT_SCALE, CFG_W'(os));
    endtask

    // Mostly musical signals: held steps, slow ramps and small noise, with full-range bursts.
    task automatic queue_signal(int n);
        int kind, level, amp;
        int left = n;
        while (left > 0) begin
            kind  = $urandom_range(3);
            level = $urandom_range(65535) - 32768;
            amp   = 1 << $urandom_range(15);
            for (int i = 0; i < 20 && left > 0; i++, left--) begin
                case (kind)
                    0: sample_q.push_back(16'(level));
                    1: sample_q.push_back(16'(level + i * amp / 8));
                    2: sample_q.push_back(16'(level + $urandom_range(amp) - amp / 2));
                    default: sample_q.push_back(16'($urandom));
                endcase
            end
        end
    endtask

    task automatic queue_extremes();
        logic [15:0] edges [8] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                                   16'h0001, 16'h8000, 16'h7FFF, 16'h0000};
        foreach (edges[i]) sample_q.push_back(edges[i]);
    endtask

    initial begin
        build_tanh_lut();
        step_c = 4048; fb_k = 0; drive = 256; t_scale = 256; o_scale = 256;
        clear_ladder();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults after reset.
        queue_extremes();
        for (int i = 0; i < 10; i++) sample_q.push_back(16'h7FFF);
        wait_idle();
        // Step, drive and scale registers at their top value, the feedback gain at 65536.
        set_filter(65535, 65536, 65535, 65535, 65535);
        queue_extremes();
        wait_idle();
        // Zero scales null their terms.
        set_filter(0, 0, 0, 0, 0);
        queue_extremes();
        wait_idle();
        for (logic [CFG_IDX_W-1:0] j = CFG_OUTPUT_SCALE + 1; ; j++) begin
            write_reg(j, '1);
            if (j == CFG_LAST_IDX) break;
        end
        queue_extremes();
        wait_idle();

        set_filter(4048, 0, 256, 256, 256);
        queue_signal(300);
        wait_idle();
        set_filter(20000, 65536, 256, 256, 256);
        queue_signal(300);
        wait_idle();
        set_filter(65535, 60000, 4096, 1024, 4096);
        queue_signal(200);
        wait_idle();
        for (int ph = 0; ph < 6; ph++) begin
            set_filter($urandom_range(65535), $urandom_range(65536), $urandom_range(65535, 1),
                       $urandom_range(65535, 1), $urandom_range(65535, 1));
            queue_signal(190);
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/nllf_pkg.sv
rtl/nllf_ctrl.sv
rtl/nllf_dp.sv
rtl/nonlinear_ladder_lowpass_filter_unit.sv
rtl/nllf_checker.sv
tb/testbench.sv
